// ===== rtl/core/h264aus_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h264aus_pkg
// Shared types and constants of the H.264 access unit splitter.
// ----------------------------------------------------------------------------
package h264aus_pkg;

    localparam int unsigned WIN_DEPTH  = 6;
    localparam int unsigned FILL_BITS  = 3;
    localparam int unsigned CFG_BITS   = 24;

    localparam logic [CFG_BITS-1:0] MAX_FRAME_RESET = 24'd500000;

    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] NAL_SLICE      = 8'h01;
    localparam logic [7:0] NAL_SLICE_IDR  = 8'h05;
    localparam logic [7:0] NAL_SEI        = 8'h06;
    localparam logic [7:0] NAL_SPS        = 8'h07;
    localparam logic [7:0] NAL_PPS        = 8'h08;
    localparam logic [7:0] FIRST_MB_MASK  = 8'h80;

    localparam logic [1:0] SKIP_RELOAD    = 2'd3;

    typedef logic [WIN_DEPTH-1:0][7:0] t_win;

    typedef struct packed {
        logic slice_first;
        logic param;
    } t_scinfo;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       boundary;
        logic       last;
    } t_emit;

endpackage
`default_nettype wire

// ===== rtl/core/h264aus_scdet.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h264aus_scdet
// Start code detector: classifies the NAL unit opened at the window head.
// ----------------------------------------------------------------------------
module h264aus_scdet (
    input  wire  h264aus_pkg::t_win    i_win,
    output h264aus_pkg::t_scinfo       o_info
);

    logic       sc3;
    logic       sc4;
    logic [7:0] nal_type;
    logic       first_mb;

    always_comb begin
        sc3 = (i_win[0] == 8'h00) && (i_win[1] == 8'h00) && (i_win[2] == 8'h01);
        sc4 = !sc3 && (i_win[0] == 8'h00) && (i_win[1] == 8'h00) &&
              (i_win[2] == 8'h00) && (i_win[3] == 8'h01);
        nal_type = (sc3 ? i_win[3] : i_win[4]) & h264aus_pkg::NAL_TYPE_MASK;
        first_mb = ((sc3 ? i_win[4] : i_win[5]) & h264aus_pkg::FIRST_MB_MASK) ==
                   h264aus_pkg::FIRST_MB_MASK;
        o_info.slice_first = (sc3 || sc4) && first_mb &&
                             ((nal_type == h264aus_pkg::NAL_SLICE) ||
                              (nal_type == h264aus_pkg::NAL_SLICE_IDR));
        o_info.param = (sc3 || sc4) &&
                       ((nal_type == h264aus_pkg::NAL_SPS) ||
                        (nal_type == h264aus_pkg::NAL_PPS) ||
                        (nal_type == h264aus_pkg::NAL_SEI));
    end

endmodule
`default_nettype wire

// ===== rtl/core/h264aus_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h264aus_emit
// Frame offset tracking, frame size limit and the output register.
// ----------------------------------------------------------------------------
module h264aus_emit #(
    parameter int unsigned OFFSET_BITS = 24
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [h264aus_pkg::CFG_BITS-1:0]      i_cfg_wdata,
    input  wire  h264aus_pkg::t_emit              i_emit,
    output logic                                  o_slot_free,
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    output logic [7:0]                            o_m_tdata,
    output logic [1:0]                            o_m_tuser,
    output logic                                  o_m_tlast
);

    localparam int unsigned CW = (OFFSET_BITS > h264aus_pkg::CFG_BITS) ?
                                 OFFSET_BITS : h264aus_pkg::CFG_BITS;

    logic [h264aus_pkg::CFG_BITS-1:0] r_max;
    logic [OFFSET_BITS-1:0]           r_off;
    logic [OFFSET_BITS-1:0]           n_off;
    logic [OFFSET_BITS-1:0]           off_use;
    logic                             r_vld;
    logic                             n_vld;
    logic [7:0]                       r_byte;
    logic                             r_bvalid;
    logic                             r_first;
    logic                             r_last;
    logic                             bvalid;

    assign o_slot_free = !r_vld || i_m_tready;

    always_comb begin
        off_use = i_emit.boundary ? '0 : r_off;
        bvalid  = CW'(off_use) < CW'(r_max);
        n_off   = r_off;
        n_vld   = r_vld && !i_m_tready;
        if (i_emit.vld) begin
            n_vld = 1'b1;
            if (i_emit.last) begin
                n_off = '0;
            end else if (off_use == {OFFSET_BITS{1'b1}}) begin
                n_off = off_use;
            end else begin
                n_off = off_use + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= h264aus_pkg::MAX_FRAME_RESET;
            r_off <= '0;
            r_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_off <= n_off;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.vld) begin
            r_byte   <= i_emit.data;
            r_bvalid <= bvalid;
            r_first  <= (off_use == '0);
            r_last   <= i_emit.last;
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_byte;
    assign o_m_tuser  = {r_first, r_bvalid};
    assign o_m_tlast  = r_last;

endmodule
`default_nettype wire

// ===== rtl/core/h264_access_unit_splitter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h264_access_unit_splitter_top
// H.264 Annex B access unit splitter with a six-byte look-ahead window.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while s_tready is high and passes it on five
// bytes later, so the first five input transactions produce no output. Each
// byte is checked for a start code while it is the oldest of a full six-byte
// window; tuser[1] marks the first byte of an access unit and tuser[0] says the
// byte lies within max_frame_bytes of its frame. A tlast transaction flushes
// the window: its up to six bytes leave one per cycle while the output register
// is free, the last with tlast, with s_tready low meanwhile. Otherwise one
// byte per cycle is sustained, limited only by the single output register.
module h264_access_unit_splitter_top #(
    parameter int unsigned OFFSET_BITS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [23:0] i_cfg_wdata,     // max_frame_bytes
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,       // [7:0] stream_byte
    input  wire         i_s_tlast,       // end_of_stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,       // [7:0] out_byte
    output logic [1:0]  o_m_tuser,       // [0] byte_valid, [1] frame_first
    output logic        o_m_tlast        // stream_last
);

    localparam int unsigned FB = h264aus_pkg::FILL_BITS;
    localparam int unsigned WD = h264aus_pkg::WIN_DEPTH;

    h264aus_pkg::t_win    r_win;
    h264aus_pkg::t_win    n_win;
    h264aus_pkg::t_win    win_new;
    logic [FB-1:0]        r_fill;
    logic [FB-1:0]        n_fill;
    logic                 r_drain;
    logic                 n_drain;
    logic                 r_srch;
    logic                 n_srch;
    logic [1:0]           r_skip;
    logic [1:0]           n_skip;
    logic                 slot_free;
    logic                 acc;
    logic                 boundary;
    logic                 srch_after;
    logic [1:0]           skip_dec;
    h264aus_pkg::t_scinfo info;
    h264aus_pkg::t_emit   emit;

    assign o_s_tready = !r_drain && slot_free;
    assign acc        = i_s_tvalid && o_s_tready;

    always_comb begin
        for (int k = 0; k < WD; k++) begin
            win_new[k] = (r_fill == FB'(k)) ? i_s_tdata : r_win[k];
        end
    end

    h264aus_scdet u_scdet (
        .i_win  (win_new),
        .o_info (info)
    );

    always_comb begin
        boundary   = r_srch && (r_skip == 2'd0) && (info.param || info.slice_first);
        srch_after = r_srch && !boundary;
        skip_dec   = (r_srch && (r_skip != 2'd0)) ? r_skip - 2'd1 : r_skip;

        n_win   = r_win;
        n_fill  = r_fill;
        n_drain = r_drain;
        n_srch  = r_srch;
        n_skip  = r_skip;
        emit    = '0;

        if (r_drain) begin
            if (slot_free) begin
                emit.vld  = 1'b1;
                emit.data = r_win[0];
                emit.last = (r_fill == FB'(1));
                n_win     = {8'h00, r_win[WD-1:1]};
                n_fill    = r_fill - FB'(1);
                if (r_fill == FB'(1)) begin
                    n_drain = 1'b0;
                end
            end
        end else if (acc) begin
            if (i_s_tlast) begin
                n_win   = win_new;
                n_fill  = r_fill + FB'(1);
                n_drain = 1'b1;
                n_srch  = 1'b0;
                n_skip  = 2'd0;
            end else if (r_fill == FB'(WD - 1)) begin
                emit.vld      = 1'b1;
                emit.data     = win_new[0];
                emit.boundary = boundary;
                n_win         = {8'h00, win_new[WD-1:1]};
                if (!srch_after && info.slice_first) begin
                    n_srch = 1'b1;
                    n_skip = h264aus_pkg::SKIP_RELOAD;
                end else begin
                    n_srch = srch_after;
                    n_skip = skip_dec;
                end
            end else begin
                n_win  = win_new;
                n_fill = r_fill + FB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_srch  <= 1'b0;
            r_skip  <= 2'd0;
        end else begin
            r_win   <= n_win;
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_srch  <= n_srch;
            r_skip  <= n_skip;
        end
    end

    h264aus_emit #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_emit      (emit),
        .o_slot_free (slot_free),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
`default_nettype wire

// ===== verif/h264_access_unit_splitter_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// h264_access_unit_splitter_top_test
// Self-checking testbench of the H.264 Annex B access unit splitter.
// ----------------------------------------------------------------------------
// Feeds short directed streams and then random Annex B streams, mostly
// well-formed NAL units with random headers and payload, mixed with noise,
// zero runs and early flushes. A predictor of the look-ahead window computes
// the expected output bytes with their valid, access unit start and last
// flags, which are checked in order against every output transaction. Each
// phase runs under its own frame byte limit, the extremes included; phases
// add random gaps on both sides, a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module h264_access_unit_splitter_top_test;

    localparam int unsigned OFFSET_BITS  = 24;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned PHASES       = 8;

    typedef struct {
        logic [7:0]  data;
        logic        eos;
        int unsigned gap;
    } t_stream_item;

    typedef struct packed {
        logic [7:0] data;
        logic       au_start;
        logic       in_limit;
        logic       stream_end;
    } t_au_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    h264_access_unit_splitter_top #(
        .OFFSET_BITS(OFFSET_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // stimulus and scoreboard
    t_stream_item stream_q[$];
    t_au_byte     au_expect[$];
    int unsigned  queued_items = 0;
    int unsigned  accepted_items = 0;
    int unsigned  checked_bytes = 0;
    int unsigned  au_starts = 0;
    int unsigned  streams_done = 0;
    int unsigned  errors = 0;
    int unsigned  tx_gap_max = 0;
    int unsigned  rx_stall_max = 0;
    int unsigned  hold_req = 0;
    bit           s_took = 1'b0;
    bit           m_took = 1'b0;

    // predictor state
    logic [7:0]                          win [h264aus_pkg::WIN_DEPTH];
    int unsigned                         win_fill = 0;
    bit                                  hunting_end = 1'b0;
    logic [1:0]                          skip_left = '0;
    logic [OFFSET_BITS-1:0]              frame_pos = '0;
    logic [h264aus_pkg::CFG_BITS-1:0]    frame_limit = h264aus_pkg::MAX_FRAME_RESET;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void clear_window();
        for (int k = 0; k < h264aus_pkg::WIN_DEPTH; k++) win[k] = '0;
        win_fill    = 0;
        hunting_end = 1'b0;
        skip_left   = '0;
        frame_pos   = '0;
    endfunction

    function automatic void emit_oldest(bit boundary, bit last);
        t_au_byte r;
        if (boundary) frame_pos = '0;
        r.data       = win[0];
        r.in_limit   = (frame_pos < frame_limit);
        r.au_start   = (frame_pos == '0);
        r.stream_end = last;
        au_expect.push_back(r);
        if (frame_pos != '1) frame_pos++;
        for (int k = 0; k < h264aus_pkg::WIN_DEPTH - 1; k++) win[k] = win[k+1];
        win[h264aus_pkg::WIN_DEPTH-1] = '0;
        win_fill--;
    endfunction

    function automatic void split_byte(logic [7:0] b, logic eos);
        int unsigned sc;
        logic [7:0]  nal;
        bit          slice_first;
        bit          param_set;
        bit          boundary;
        sc          = 0;
        slice_first = 1'b0;
        param_set   = 1'b0;
        boundary    = 1'b0;
        if (win_fill < h264aus_pkg::WIN_DEPTH) begin
            win[win_fill] = b;
            win_fill++;
        end
        if (eos) begin
            while (win_fill > 0) emit_oldest(1'b0, win_fill == 1);
            clear_window();
            return;
        end
        if (win_fill == h264aus_pkg::WIN_DEPTH) begin
            if (win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h01)
                sc = 3;
            else if (win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h00
                     && win[3] == 8'h01)
                sc = 4;
            if (sc != 0) begin
                nal = win[sc] & h264aus_pkg::NAL_TYPE_MASK;
                slice_first = (nal == h264aus_pkg::NAL_SLICE
                               || nal == h264aus_pkg::NAL_SLICE_IDR)
                              && ((win[sc+1] & h264aus_pkg::FIRST_MB_MASK)
                                  == h264aus_pkg::FIRST_MB_MASK);
                param_set = (nal == h264aus_pkg::NAL_SPS || nal == h264aus_pkg::NAL_PPS
                             || nal == h264aus_pkg::NAL_SEI);
            end
            if (hunting_end) begin
                if (skip_left != 0) begin
                    skip_left--;
                end else if (param_set || slice_first) begin
                    boundary    = 1'b1;
                    hunting_end = 1'b0;
                end
            end
            if (!hunting_end && slice_first) begin
                hunting_end = 1'b1;
                skip_left   = h264aus_pkg::SKIP_RELOAD;
            end
            emit_oldest(boundary, 1'b0);
        end
    endfunction

    function automatic void add_byte(logic [7:0] b, logic eos);
        t_stream_item it;
        it.data = b;
        it.eos  = eos;
        it.gap  = $urandom_range(0, tx_gap_max);
        stream_q.push_back(it);
        queued_items++;
    endfunction

    function automatic logic [7:0] nal_header();
        logic [4:0] t;
        case ($urandom_range(0, 7))
            0, 1:    t = h264aus_pkg::NAL_SLICE[4:0];
            2, 3:    t = h264aus_pkg::NAL_SLICE_IDR[4:0];
            4:       t = h264aus_pkg::NAL_SPS[4:0];
            5:       t = h264aus_pkg::NAL_PPS[4:0];
            6:       t = h264aus_pkg::NAL_SEI[4:0];
            default: t = 5'($urandom_range(0, 31));
        endcase
        return {3'($urandom_range(0, 7)), t};
    endfunction

    // Annex B stream: mostly NAL units with random content, some noise.
    task automatic queue_stream(int unsigned n_bytes, bit close);
        int unsigned start;
        int unsigned len;
        logic [7:0]  hdr;
        start = queued_items;
        while (queued_items - start < n_bytes) begin
            case ($urandom_range(0, 9))
                8: begin
                    len = $urandom_range(1, 5);
                    repeat (len) add_byte(8'h00, 1'b0);
                    add_byte(8'h01, 1'b0);
                end
                9: begin
                    len = $urandom_range(1, 8);
                    for (int k = 1; k <= len; k++)
                        add_byte(8'($urandom_range(0, 255)),
                                 k == len && $urandom_range(0, 2) == 0);
                end
                default: begin
                    if ($urandom_range(0, 1)) add_byte(8'h00, 1'b0);
                    add_byte(8'h00, 1'b0);
                    add_byte(8'h00, 1'b0);
                    add_byte(8'h01, 1'b0);
                    hdr = nal_header();
                    add_byte(hdr, 1'b0);
                    if ((hdr & h264aus_pkg::NAL_TYPE_MASK) == h264aus_pkg::NAL_SLICE
                        || (hdr & h264aus_pkg::NAL_TYPE_MASK) == h264aus_pkg::NAL_SLICE_IDR)
                        add_byte({($urandom_range(0, 3) != 0), 7'($urandom_range(0, 127))},
                                 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end
        if (close) add_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_results();
        do @(negedge i_clk);
        while (accepted_items != queued_items || au_expect.size() != 0);
    endtask

    task automatic write_limit(logic [h264aus_pkg::CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_limit = value;
    endtask

    // sender
    always @(negedge i_clk) begin : sender
        int unsigned  tx_wait;
        t_stream_item cur;
        if (!i_s_tvalid || s_took) begin
            if (stream_q.size() != 0 && tx_wait < stream_q[0].gap) begin
                tx_wait++;
                i_s_tvalid <= 1'b0;
            end else if (stream_q.size() != 0) begin
                cur = stream_q.pop_front();
                tx_wait = 0;
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= cur.data;
                i_s_tlast  <= cur.eos;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin : receiver
        int unsigned hold_left;
        int unsigned rx_wait;
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (m_took) rx_wait = $urandom_range(0, rx_stall_max);
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor: check output first, then predict from the accepted input
    always @(posedge i_clk) begin : monitor
        t_au_byte want;
        t_au_byte got;
        s_took = i_rst_n && i_s_tvalid && o_s_tready;
        m_took = i_rst_n && o_m_tvalid && i_m_tready;
        if (m_took) begin
            got = {o_m_tdata, o_m_tuser[1], o_m_tuser[0], o_m_tlast};
            if (au_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction data %h start %b valid %b last %b",
                         $time, got.data, got.au_start, got.in_limit, got.stream_end);
            end else begin
                want = au_expect.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected data %h start %b valid %b last %b, got %h %b %b %b",
                             $time, want.data, want.au_start, want.in_limit, want.stream_end,
                             got.data, got.au_start, got.in_limit, got.stream_end);
                end
            end
            checked_bytes++;
            if (o_m_tuser[1]) au_starts++;
            if (o_m_tlast) streams_done++;
        end
        if (s_took) begin
            split_byte(i_s_tdata, i_s_tlast);
            accepted_items++;
        end
    end

    logic [7:0] dir_seq [23] = '{
        8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h80,
        8'h00, 8'h00, 8'h01, 8'h41, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42,
        8'h00, 8'h00, 8'h01, 8'h41, 8'h80, 8'hFF
    };

    logic [h264aus_pkg::CFG_BITS-1:0] phase_limit [PHASES];

    initial begin
        clear_window();
        phase_limit = '{24'd0, 24'd1, 24'hFFFFFF, 24'd5,
                        h264aus_pkg::CFG_BITS'($urandom_range(2, 40)), 24'd12, 24'd40,
                        h264aus_pkg::CFG_BITS'($urandom_range(1, 24'hFFFFFF))};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-byte stream, then slices, SPS and start code variants
        add_byte(8'hFF, 1'b1);
        foreach (dir_seq[k]) add_byte(dir_seq[k], k == 22);
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limit[p]);
            tx_gap_max   = (p % 3 == 1 || p == 2) ? 0 : 11;
            rx_stall_max = (p % 4 == 0) ? 0 : 11;
            if (p == 2) begin
                queue_stream(50, 1'b1);
                hold_req = 150;
            end else if (p == 4) begin
                queue_stream(25, 1'b0);
                wait_results();
                queue_stream(25, 1'b1);
            end else begin
                queue_stream(50, 1'b1);
            end
            wait_results();
            repeat (DRAIN_CYCLES) @(negedge i_clk);
        end

        $display("Checked %0d output bytes over %0d streams, %0d access unit starts,",
                 checked_bytes, streams_done, au_starts);
        $display("frame limits from 0 to 16777215 with gaps, stalls and a long hold-off.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
